FILE: src/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// tcpq_pkg
// shared types, codes and defaults for the three class priority queue
// ----------------------------------------------------------------------------
package tcpq_pkg;

    localparam int DEF_CLASS_DEPTH = 16;
    localparam int DEF_NUM_CLASSES = 3;

    localparam int PRIO_W   = 2;
    localparam int ITEMS_W  = 10;
    localparam int KEY_W    = 37;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 6;
    localparam int ENTRY_W  = ITEMS_W + KEY_W;

    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 64;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BAD   = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

FILE: src/three_class_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// three_class_priority_queue_unit
// strict priority queue, one fifo per class, class 1 served first
// ----------------------------------------------------------------------------
// channel   dir  contents
// s         in   tuser: operation; tdata: priority_req, item_count, customer_key
// m         out  tdata: status, out_priority, out_items, out_key, occupancy,
//                is_empty
//
// each request takes two steps: one to latch it, one to update the class
// pointers and write or pop the entry memory; the head of the best class is
// read from the memory while the block waits, so a dequeue needs no extra step
// a new request is taken while the previous result still waits on m
// a stalled result holds the commit of the next request until the slot frees
// reset empties every class at once; entries need no clearing
// ----------------------------------------------------------------------------
module three_class_priority_queue_unit #(
    parameter int CLASS_DEPTH = tcpq_pkg::DEF_CLASS_DEPTH,
    parameter int NUM_CLASSES = tcpq_pkg::DEF_NUM_CLASSES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // priority_req[1:0], item_count[11:2], customer_key[48:12], zero pad
    input  logic [tcpq_pkg::S_DATA_W-1:0] i_s_tdata,
    // operation
    input  logic                          i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // status[1:0], out_priority[3:2], out_items[13:4], out_key[50:14],
    // occupancy[56:51], is_empty[57], zero pad
    output logic [tcpq_pkg::M_DATA_W-1:0] o_m_tdata
);
    import tcpq_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    tcpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    tcpq_dp #(
        .CLASS_DEPTH (CLASS_DEPTH),
        .NUM_CLASSES (NUM_CLASSES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

FILE: src/tcpq_ctrl.sv
// ----------------------------------------------------------------------------
// tcpq_ctrl
// request sequencer: takes a request, then commits it once the result slot frees
// ----------------------------------------------------------------------------
module tcpq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    output tcpq_pkg::t_dp_cmd  o_cmd,
    input  tcpq_pkg::t_dp_stat i_stat
);
    import tcpq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

FILE: src/tcpq_dp.sv
// ----------------------------------------------------------------------------
// tcpq_dp
// class pointers, counts, entry memory and the result register
// ----------------------------------------------------------------------------
module tcpq_dp #(
    parameter int CLASS_DEPTH = tcpq_pkg::DEF_CLASS_DEPTH,
    parameter int NUM_CLASSES = tcpq_pkg::DEF_NUM_CLASSES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tcpq_pkg::t_dp_cmd             i_cmd,
    output tcpq_pkg::t_dp_stat            o_stat,
    input  logic [tcpq_pkg::S_DATA_W-1:0] i_s_tdata,
    input  logic                          i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [tcpq_pkg::M_DATA_W-1:0] o_m_tdata
);
    import tcpq_pkg::*;

    localparam int PW        = $clog2(CLASS_DEPTH);
    localparam int CW        = $clog2(CLASS_DEPTH + 1);
    localparam int CIW       = $clog2(NUM_CLASSES);
    localparam int AW        = CIW + PW;
    localparam int MEM_DEPTH = NUM_CLASSES << PW;
    localparam int RES_W     = STATUS_W + PRIO_W + ENTRY_W + OCC_W + 1;

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] p);
        f_next = (p == PW'(CLASS_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // latched request
    logic               r_op;
    logic [PRIO_W-1:0]  r_prio;
    logic [ITEMS_W-1:0] r_items;
    logic [KEY_W-1:0]   r_key;

    logic [PW-1:0]      r_head  [NUM_CLASSES];
    logic [PW-1:0]      r_tail  [NUM_CLASSES];
    logic [CW-1:0]      r_count [NUM_CLASSES];
    logic [OCC_W-1:0]   r_occ;

    logic [PW-1:0]      n_head  [NUM_CLASSES];
    logic [PW-1:0]      n_tail  [NUM_CLASSES];
    logic [CW-1:0]      n_count [NUM_CLASSES];
    logic [OCC_W-1:0]   n_occ;

    logic [ENTRY_W-1:0] mem [MEM_DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;

    logic               r_out_valid;
    logic [RES_W-1:0]   r_out_data;

    logic               found;
    logic [CIW-1:0]     best;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               wr_en;
    logic               cls_ok;
    logic [CIW-1:0]     ci;
    logic [STATUS_W-1:0] st;
    logic [PRIO_W-1:0]  prio_o;
    logic [ITEMS_W-1:0] items_o;
    logic [KEY_W-1:0]   key_o;
    logic               n_empty;

    // best non-empty class
    always_comb begin
        found = 1'b0;
        best  = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (r_count[c] != '0) begin
                found = 1'b1;
                best  = CIW'(c);
            end
        end
    end

    assign rd_addr = {best, r_head[best]};
    assign cls_ok  = (r_prio != '0) && (int'(r_prio) <= NUM_CLASSES);
    assign ci      = CIW'(int'(r_prio) - 1);
    assign wr_addr = {ci, r_tail[ci]};

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_occ   = r_occ;
        st      = STAT_OK;
        prio_o  = '0;
        items_o = '0;
        key_o   = '0;
        wr_en   = 1'b0;
        n_empty = 1'b1;
        if (r_op == OP_ENQ) begin
            if (!cls_ok) begin
                st = STAT_BAD;
            end else if (r_count[ci] == CW'(CLASS_DEPTH)) begin
                st = STAT_FULL;
            end else begin
                wr_en       = 1'b1;
                n_tail[ci]  = f_next(r_tail[ci]);
                n_count[ci] = r_count[ci] + 1'b1;
                n_occ       = r_occ + 1'b1;
            end
        end else begin
            if (!found) begin
                st = STAT_EMPTY;
            end else begin
                prio_o        = PRIO_W'(int'(best) + 1);
                items_o       = r_rd_data[ENTRY_W-1:KEY_W];
                key_o         = r_rd_data[KEY_W-1:0];
                n_count[best] = r_count[best] - 1'b1;
                n_occ         = r_occ - 1'b1;
                if (r_count[best] == CW'(1)) begin
                    n_head[best] = '0;
                    n_tail[best] = '0;
                end else begin
                    n_head[best] = f_next(r_head[best]);
                end
            end
        end
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (n_count[c] != '0) begin
                n_empty = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_s_tuser;
            r_prio  <= i_s_tdata[PRIO_W-1:0];
            r_items <= i_s_tdata[PRIO_W+ITEMS_W-1:PRIO_W];
            r_key   <= i_s_tdata[PRIO_W+ITEMS_W+KEY_W-1:PRIO_W+ITEMS_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && wr_en) begin
            mem[wr_addr] <= {r_items, r_key};
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_head[c]  <= '0;
                r_tail[c]  <= '0;
                r_count[c] <= '0;
            end
            r_occ <= '0;
        end else if (i_cmd.commit) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_occ   <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= {n_empty, n_occ, key_o, items_o, prio_o, st};
        end
    end

    assign o_stat.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid      = r_out_valid;
    assign o_m_tdata       = {(M_DATA_W - RES_W)'(0), r_out_data};

endmodule

FILE: src/tcpq_chk.sv
// ----------------------------------------------------------------------------
// tcpq_chk
// port level checks for the priority queue, bound to the top level
// ----------------------------------------------------------------------------
module tcpq_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [tcpq_pkg::M_DATA_W-1:0] o_m_tdata
);
    import tcpq_pkg::*;

    // no second request right behind an accepted one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request taken while the previous one is in work");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

    // an empty queue reports zero occupancy
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[57]) |-> (o_m_tdata[56:51] == 6'd0))
        else $error("empty flag with nonzero occupancy");

    // a failed request carries no entry
    a_fail_no_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[1:0] != STAT_OK)) |-> (o_m_tdata[50:2] == '0))
        else $error("failed request returned an entry");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && o_s_tready))
        else $error("result pending or busy after reset");

endmodule

bind three_class_priority_queue_unit tcpq_chk u_tcpq_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
